// ===== rtl/core/brf_pkg.sv =====
// Package with the byte ring FIFO command codes, payload types and sizing constants.
package brf_pkg;

    localparam int unsigned CAPACITY_DEF = 1024;
    localparam int unsigned CMD_W        = 3;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned DCNT_W       = 32;
    localparam int unsigned CNT_W        = 11;
    localparam int unsigned TOT_W        = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH    = 3'd0,
        CMD_POP     = 3'd1,
        CMD_PEEK    = 3'd2,
        CMD_DISCARD = 3'd3,
        CMD_CLEAR   = 3'd4
    } brf_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] data_in;
        logic [DCNT_W-1:0] discard_count;
    } brf_in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_out;
        logic              ok;
        logic [CNT_W-1:0]  moved_count;
        logic [CNT_W-1:0]  readable_bytes;
        logic              is_empty;
        logic              is_full;
        logic [TOT_W-1:0]  attempted_total;
        logic [TOT_W-1:0]  lost_total;
    } brf_out_t;

endpackage

// ===== rtl/core/brf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module brf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/byte_ring_fifo_overwrite_top.sv =====
// Top level of the byte ring FIFO with reject or overwrite on full.
// Each result passes the stage-one register (state update and RAM read), then
// the result register. Throughput: one command per cycle while rsp_ready does not
// hold the result register; the RAM read of the head byte sets the extra stage.
// Reset clears pointers, totals, the overwrite mode and all valid flags;
// byte storage is not cleared and is read only where it was written.
module byte_ring_fifo_overwrite_top #(
    parameter int unsigned CAPACITY = brf_pkg::CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  brf_pkg::brf_in_t  req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output brf_pkg::brf_out_t rsp,
    input  logic              cfg_we,
    input  logic              cfg_wdata
);

    import brf_pkg::*;

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned PW = AW + 1;

    logic [PW-1:0]     head_reg, head_next;
    logic [PW-1:0]     tail_reg, tail_next;
    logic [TOT_W-1:0]  offered_reg, offered_next;
    logic [TOT_W-1:0]  dropped_reg, dropped_next;
    logic              mode_reg;

    logic              s1_valid_reg;
    logic              s1_rd_reg;
    brf_out_t          s1_reg, s1_next;
    logic              rsp_valid_reg;
    brf_out_t          rsp_reg, rsp_next;

    logic [PW-1:0]     held, held_after;
    logic              full_now;
    logic [PW-1:0]     disc_n;
    logic              rd_next;
    logic              ram_we;
    logic              accept;
    logic              s1_move;
    logic [BYTE_W-1:0] ram_rdata;

    assign s1_move   = !rsp_valid_reg || rsp_ready;
    assign req_ready = !s1_valid_reg || s1_move;
    assign accept    = req_valid && req_ready;

    assign held     = tail_reg - head_reg;
    assign full_now = (held == PW'(CAPACITY));
    assign disc_n   = (req.discard_count > DCNT_W'(held)) ? held : PW'(req.discard_count);

    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        offered_next = offered_reg;
        dropped_next = dropped_reg;
        ram_we       = 1'b0;
        rd_next      = 1'b0;
        s1_next      = '0;
        unique case (req.cmd)
            CMD_PUSH:
            begin
                offered_next = offered_reg + TOT_W'(1);
                if (full_now)
                begin
                    dropped_next = dropped_reg + TOT_W'(1);
                end
                if (!full_now || mode_reg)
                begin
                    if (full_now)
                    begin
                        head_next = head_reg + PW'(1);
                    end
                    tail_next           = tail_reg + PW'(1);
                    ram_we              = accept;
                    s1_next.ok          = 1'b1;
                    s1_next.moved_count = CNT_W'(1);
                end
            end
            CMD_POP, CMD_PEEK:
            begin
                if (held != '0)
                begin
                    rd_next    = 1'b1;
                    s1_next.ok = 1'b1;
                    if (req.cmd == CMD_POP)
                    begin
                        head_next           = head_reg + PW'(1);
                        s1_next.moved_count = CNT_W'(1);
                    end
                end
            end
            CMD_DISCARD:
            begin
                head_next           = head_reg + disc_n;
                s1_next.moved_count = CNT_W'(disc_n);
            end
            CMD_CLEAR:
            begin
                head_next    = '0;
                tail_next    = '0;
                offered_next = '0;
                dropped_next = '0;
            end
            default:
            begin
            end
        endcase
        held_after              = tail_next - head_next;
        s1_next.readable_bytes  = CNT_W'(held_after);
        s1_next.is_empty        = (held_after == '0);
        s1_next.is_full         = (held_after == PW'(CAPACITY));
        s1_next.attempted_total = offered_next;
        s1_next.lost_total      = dropped_next;
    end

    always_comb
    begin
        rsp_next          = s1_reg;
        rsp_next.data_out = s1_rd_reg ? ram_rdata : '0;
    end

    brf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg[AW-1:0]),
        .wdata (req.data_in),
        .re    (accept),
        .raddr (head_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            offered_reg   <= '0;
            dropped_reg   <= '0;
            mode_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (accept)
            begin
                head_reg    <= head_next;
                tail_reg    <= tail_next;
                offered_reg <= offered_next;
                dropped_reg <= dropped_next;
            end
            if (req_ready)
            begin
                s1_valid_reg <= req_valid;
            end
            if (s1_move)
            begin
                rsp_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg    <= s1_next;
            s1_rd_reg <= rd_next;
        end
        if (s1_move && s1_valid_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
